>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the header framer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, ignored while reset is held.
`define ETHTX_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ethtx assertion failed");

// Expression that must never be true outside reset.
`define ETHTX_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  `ETHTX_ASSERT(lbl, clk, rst_n, !(expr))

`endif

>>> rtl/core/ethtx_pkg.sv
// ----------------------------------------------------------------------------
// ethtx_pkg
// Shared constants, types and helpers of the Ethernet transmit header framer.
// ----------------------------------------------------------------------------
package ethtx_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);

  localparam int MAC_W  = 48;
  localparam int DATA_W = 64;
  localparam int KEEP_W = 8;
  localparam int DEST_W = 8;
  localparam int IDX_W  = 8;

  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 72;

  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 64;
  localparam int CFG_IDX_W  = CFG_AW - 3;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MAC = '0;

  localparam logic [15:0]       ETHERTYPE = 16'h7400;
  localparam logic [KEEP_W-1:0] KEEP_ALL  = 8'hff;

  localparam logic OP_TABLE_WRITE = 1'b0;
  localparam logic OP_FLIT        = 1'b1;

  typedef enum logic [1:0] {
    PH_HDR0,
    PH_HDR1,
    PH_FLIT
  } phase_t;

  // Flit handed from the input stage to the word emitter
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [KEEP_W-1:0] keep;
    logic              last;
    logic [DEST_W-1:0] dest;
    logic              first;
    logic              dest_ok;
  } flit_t;

  function automatic logic [63:0] swap_bytes64(input logic [63:0] v);
    logic [63:0] r;
    r = '0;
    for (int b = 0; b < 8; b++) begin
      r[8*b +: 8] = v[8*(7-b) +: 8];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/ethtx_ram.sv
// ----------------------------------------------------------------------------
// ethtx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ethtx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/ethtx_cfg.sv
// ----------------------------------------------------------------------------
// ethtx_cfg
// APB register file holding the source MAC address.
// ----------------------------------------------------------------------------
module ethtx_cfg
  import ethtx_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [MAC_W-1:0]  source_mac
);

  logic [MAC_W-1:0]     source_mac_r;
  logic [MAC_W-1:0]     source_mac_nxt;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic                 wr_fire;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:3];
  assign wr_fire = psel && penable && pwrite && pready;

  always_comb begin
    source_mac_nxt = source_mac_r;
    if (wr_fire && reg_idx == REG_SOURCE_MAC) begin
      source_mac_nxt = pwdata[MAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_mac_r <= '0;
    end else begin
      source_mac_r <= source_mac_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_SOURCE_MAC) begin
      prdata = {{(CFG_DW-MAC_W){1'b0}}, source_mac_r};
    end
  end

  assign source_mac = source_mac_r;

endmodule

>>> rtl/core/ethtx_emit.sv
// ----------------------------------------------------------------------------
// ethtx_emit
// Holds one flit, builds the two header words from the table read data and
// sends header and flit words through the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ethtx_emit
  import ethtx_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_valid,
  input  flit_t                  push_flit,
  output logic                   push_ready,
  input  logic [MAC_W-1:0]       dest_mac,
  input  logic [MAC_W-1:0]       source_mac,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic                   out_tuser
);

  logic   s1_valid_r;
  logic   s1_valid_nxt;
  flit_t  s1_r;
  flit_t  s1_nxt;
  phase_t phase_r;
  phase_t phase_nxt;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [DATA_W-1:0] out_data_r;
  logic [DATA_W-1:0] out_data_nxt;
  logic [KEEP_W-1:0] out_keep_r;
  logic [KEEP_W-1:0] out_keep_nxt;
  logic              out_last_r;
  logic              out_last_nxt;
  logic              out_end_r;
  logic              out_end_nxt;

  logic              out_load;
  logic              emit;
  logic              s1_done;
  logic              push_fire;
  logic [MAC_W-1:0]  dmac;
  logic [DATA_W-1:0] word_data;
  logic [KEEP_W-1:0] word_keep;
  logic              word_last;
  logic              word_end;

  assign out_load   = !out_valid_r || out_tready;
  assign emit       = s1_valid_r && out_load;
  assign s1_done    = emit && (phase_r == PH_FLIT);
  assign push_ready = !s1_valid_r || s1_done;
  assign push_fire  = push_valid && push_ready;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (push_fire) begin
      phase_nxt = push_flit.first ? PH_HDR0 : PH_FLIT;
    end else if (emit) begin
      case (phase_r)
        PH_HDR0: phase_nxt = PH_HDR1;
        PH_HDR1: phase_nxt = PH_FLIT;
        PH_FLIT: phase_nxt = PH_FLIT;
        default: phase_nxt = PH_FLIT;
      endcase
    end
  end

  // word for the current phase
  always_comb begin
    dmac      = s1_r.dest_ok ? dest_mac : '0;
    word_data = s1_r.data;
    word_keep = s1_r.keep;
    word_last = s1_r.last;
    word_end  = 1'b1;
    case (phase_r)
      PH_HDR0: begin
        word_data = swap_bytes64({dmac, source_mac[47:32]});
        word_keep = KEEP_ALL;
        word_last = 1'b0;
        word_end  = 1'b0;
      end
      PH_HDR1: begin
        word_data = swap_bytes64({source_mac[31:0], ETHERTYPE, s1_r.dest, 8'h00});
        word_keep = KEEP_ALL;
        word_last = 1'b0;
        word_end  = 1'b0;
      end
      PH_FLIT: begin
        word_data = s1_r.data;
      end
      default: begin
        word_data = s1_r.data;
      end
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_nxt       = s1_r;
    if (push_fire) begin
      s1_valid_nxt = 1'b1;
      s1_nxt       = push_flit;
    end else if (s1_done) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_keep_nxt  = out_keep_r;
    out_last_nxt  = out_last_r;
    out_end_nxt   = out_end_r;
    if (out_load) begin
      out_valid_nxt = emit;
      out_data_nxt  = word_data;
      out_keep_nxt  = word_keep;
      out_last_nxt  = word_last;
      out_end_nxt   = word_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      phase_r     <= PH_FLIT;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r       <= s1_nxt;
    out_data_r <= out_data_nxt;
    out_keep_r <= out_keep_nxt;
    out_last_r <= out_last_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_keep_r, out_data_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_end_r;

  `ETHTX_ASSERT(a_hdr_word_shape, clk, rst_n,
    (out_valid_r && !out_end_r) |-> (out_keep_r == KEEP_ALL && !out_last_r))
  `ETHTX_ASSERT(a_cont_flit_direct, clk, rst_n,
    (s1_valid_r && !s1_r.first) |-> (phase_r == PH_FLIT))
  `ETHTX_ASSERT(a_first_starts_hdr, clk, rst_n,
    (push_fire && push_flit.first) |=> (s1_valid_r && phase_r == PH_HDR0))
  `ETHTX_ASSERT_NEVER(a_push_while_hdr, clk, rst_n,
    push_fire && s1_valid_r && phase_r != PH_FLIT)

endmodule

>>> rtl/core/eth_tx_header_framer.sv
// ----------------------------------------------------------------------------
// eth_tx_header_framer
// Ethernet transmit framer: MAC table, header insertion and flit forwarding.
// ----------------------------------------------------------------------------
// Each input word is either a MAC table write (tuser 0) or an application
// flit (tuser 1). Table writes and continuation flits are taken one per
// cycle while the emitter can take a flit; the first flit of a packet
// occupies the emitter until its two header words and the flit itself have
// left, one word per cycle while out_tready allows, through the single
// output register. The destination MAC is read from a 256 x 48 synchronous
// RAM when the first flit is accepted and taken from the registered read
// data when the header words are built. A write to the table is visible to
// any flit accepted in the following cycle. Entries are undefined until
// written; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module eth_tx_header_framer
  import ethtx_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: entry_index[7:0], entry_mac[55:8], flit_data[119:56],
  //           flit_keep[127:120], flit_dest[135:128]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,   // flit_last
  input  logic                   in_tuser,   // op
  // out_tdata: out_data[63:0], out_keep[71:64]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,  // out_last
  output logic                   out_tuser,  // run_end
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [CFG_DW-1:0]      cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  logic [IDX_W-1:0]  entry_index;
  logic [MAC_W-1:0]  entry_mac;
  logic [DATA_W-1:0] flit_data;
  logic [KEEP_W-1:0] flit_keep;
  logic [DEST_W-1:0] flit_dest;

  logic             in_fire;
  logic             is_flit;
  logic             mid_packet_r;
  logic             mid_packet_nxt;
  logic             idx_ok;
  logic             dest_ok;
  logic             tbl_we;
  logic             tbl_re;
  logic [MAC_W-1:0] tbl_rd_data;
  logic [MAC_W-1:0] source_mac;
  logic             push_ready;
  flit_t            push_flit;

  assign entry_index = in_tdata[7:0];
  assign entry_mac   = in_tdata[55:8];
  assign flit_data   = in_tdata[119:56];
  assign flit_keep   = in_tdata[127:120];
  assign flit_dest   = in_tdata[135:128];

  assign is_flit   = (in_tuser == OP_FLIT);
  assign in_tready = push_ready;
  assign in_fire   = in_tvalid && in_tready;

  assign idx_ok  = {1'b0, entry_index} < (IDX_W+1)'(TABLE_DEPTH);
  assign dest_ok = {1'b0, flit_dest} < (DEST_W+1)'(TABLE_DEPTH);

  assign tbl_we = in_fire && (in_tuser == OP_TABLE_WRITE) && idx_ok;
  // look up only at packet start; read data holds while the headers go out
  assign tbl_re = in_fire && is_flit && !mid_packet_r;

  always_comb begin
    mid_packet_nxt = mid_packet_r;
    if (in_fire && is_flit) begin
      mid_packet_nxt = !in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_packet_r <= 1'b0;
    end else begin
      mid_packet_r <= mid_packet_nxt;
    end
  end

  always_comb begin
    push_flit.data    = flit_data;
    push_flit.keep    = flit_keep;
    push_flit.last    = in_tlast;
    push_flit.dest    = flit_dest;
    push_flit.first   = !mid_packet_r;
    push_flit.dest_ok = dest_ok;
  end

  ethtx_ram #(
    .WIDTH (MAC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_mac_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (entry_index[TBL_AW-1:0]),
    .wr_data (entry_mac),
    .rd_en   (tbl_re),
    .rd_addr (flit_dest[TBL_AW-1:0]),
    .rd_data (tbl_rd_data)
  );

  ethtx_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready),
    .source_mac (source_mac)
  );

  ethtx_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid && is_flit),
    .push_flit  (push_flit),
    .push_ready (push_ready),
    .dest_mac   (tbl_rd_data),
    .source_mac (source_mac),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
